// File: rtl/aba_pkg.sv
// Package for the accumulator bank ALU: field widths, opcode, status and
// compare-flag codes, and the control/status structs between the units.
// No dependencies.
`timescale 1ns / 1ps

package aba_pkg;

   // Field and datapath widths
   localparam int ACC_W = 64;
   localparam int SRC_W = 32;
   localparam int CMD_W = 3;
   localparam int IDX_W = 4;
   localparam int ST_W  = 2;
   localparam int CMP_W = 2;
   localparam int CNT_W = $clog2(ACC_W);

   // Instruction codes
   localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DIV   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CMP   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_JEQ   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_NOP   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd6;

   // Response status codes
   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_BAD_DEST = 2'd1;
   localparam logic [ST_W-1:0] ST_TRAP     = 2'd2;

   // Compare flag, two's complement: 0 equal, +1 greater, -1 less
   localparam logic [CMP_W-1:0] CMP_EQ = 2'b00;
   localparam logic [CMP_W-1:0] CMP_GT = 2'b01;
   localparam logic [CMP_W-1:0] CMP_LT = 2'b11;

   // Bit-serial add/compare unit
   typedef struct packed {
      logic start;
      logic sub;
   } aba_ser_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic lt;
      logic ne;
   } aba_ser_sts_type;

   // Iterative divider
   typedef struct packed {
      logic busy;
      logic done;
   } aba_div_sts_type;

endpackage

// File: rtl/aba_if.sv
// Valid/ready channel interfaces for the accumulator bank ALU: the request
// channel and the response channel. Depends on aba_pkg.
`timescale 1ns / 1ps

interface aba_req_if import aba_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [IDX_W-1:0]        dest_index;
   logic                    src_is_constant;
   logic signed [SRC_W-1:0] src_value;
   logic                    program_start;

   modport source (output valid, cmd, dest_index, src_is_constant, src_value,
                   program_start, input ready);
   modport sink (input valid, cmd, dest_index, src_is_constant, src_value,
                 program_start, output ready);
endinterface

interface aba_rsp_if import aba_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ST_W-1:0]         status;
   logic                    branch_taken;
   logic signed [CMP_W-1:0] compare_state;
   logic signed [ACC_W-1:0] dest_value;
   logic                    trap_sticky;
   logic signed [ACC_W-1:0] trap_value;

   modport source (output valid, status, branch_taken, compare_state, dest_value,
                   trap_sticky, trap_value, input ready);
   modport sink (input valid, status, branch_taken, compare_state, dest_value,
                 trap_sticky, trap_value, output ready);
endinterface

// File: rtl/accumulator_bank_alu.sv
// Accumulator bank ALU, top level.
// Each request on req_chan is one instruction (add, sub, divide, compare,
// jump-if-equal test, nop, clear all) against a bank of NUM_ACC signed 64-bit
// accumulators; each request yields exactly one response on rsp_chan with the
// status, branch flag, compare flag, destination value and trap state.
// One request is in flight at a time: req_chan.ready is high while idle.
// How each request runs, from accept to response valid:
//   add, sub, cmp: on the bit-serial adder, one bit a cycle.
//   div: on the divider, one quotient bit a cycle, after a magnitude step
//        for each operand and before a sign-fix step on its shared negator.
//   jeq, nop, clear, bad destination, divide trap: no unit is started.
// The accumulators sit in a RAM with a valid bit per entry; reset and clear
// drop the valid bits, so an entry reads as zero until written. Reset also
// zeroes the trap flag and value and sets the compare flag to equal.
// The response sits in an output register; if the receiver stalls, the next
// request is still accepted and runs, and its result waits until the
// previous response is taken.
// Depends on aba_pkg, aba_if, aba_ram, aba_serial and aba_div.
`timescale 1ns / 1ps

module accumulator_bank_alu import aba_pkg::*; #(
   parameter int NUM_ACC = 10
) (
   input  logic      clock,
   input  logic      reset,
   aba_req_if.sink   req_chan,
   aba_rsp_if.source rsp_chan
);

   localparam int ADDR_W = (NUM_ACC > 1) ? $clog2(NUM_ACC) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_SER  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   // Control state
   logic [2:0]         state_ff, state_in;
   logic [NUM_ACC-1:0] acc_vld_ff, acc_vld_in;
   logic [CMP_W-1:0]   cflag_ff, cflag_in;
   logic               trap_flag_ff, trap_flag_in;
   logic               rsp_vld_ff, rsp_vld_in;

   // Captured request
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [IDX_W-1:0]   dest_ff, dest_in;
   logic               const_ff, const_in;
   logic [SRC_W-1:0]   src_val_ff, src_val_in;
   logic               dest_ok_ff, dest_ok_in;
   logic               dest_vld_ff, dest_vld_in;
   logic               src_vld_ff, src_vld_in;

   // Pending result and state updates
   logic [ST_W-1:0]    status_ff, status_in;
   logic               branch_ff, branch_in;
   logic [ACC_W-1:0]   res_val_ff, res_val_in;
   logic               wr_en_ff, wr_en_in;
   logic               trap_set_ff, trap_set_in;
   logic               clr_ff, clr_in;
   logic               cmp_set_ff, cmp_set_in;
   logic [CMP_W-1:0]   cmp_new_ff, cmp_new_in;
   logic [ACC_W-1:0]   trap_val_ff, trap_val_in;

   // Response register
   logic [ST_W-1:0]    rsp_status_ff, rsp_status_in;
   logic               rsp_branch_ff, rsp_branch_in;
   logic [CMP_W-1:0]   rsp_cmp_ff, rsp_cmp_in;
   logic [ACC_W-1:0]   rsp_dest_ff, rsp_dest_in;
   logic               rsp_trap_ff, rsp_trap_in;
   logic [ACC_W-1:0]   rsp_trap_val_ff, rsp_trap_val_in;

   logic               req_fire, rsp_fire, fin_go;
   logic               req_dest_ok, req_src_ok;
   logic [ADDR_W-1:0]  req_dest_addr, req_src_addr, dest_addr;
   logic [ACC_W-1:0]   rd_a, rd_b, dval, opnd;
   logic               ram_we;
   aba_ser_ctl_type    ser_ctl;
   aba_ser_sts_type    ser_sts;
   logic [ACC_W-1:0]   ser_sum;
   logic               div_start;
   aba_div_sts_type    div_sts;
   logic [ACC_W-1:0]   div_q;

   // Handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_vld_ff && rsp_chan.ready;
   assign fin_go         = (state_ff == S_FIN) && (!rsp_vld_ff || rsp_chan.ready);

   // Index checks on the incoming request
   assign req_dest_ok   = ({1'b0, req_chan.dest_index} < 5'(NUM_ACC));
   assign req_src_ok    = !req_chan.src_value[SRC_W-1]
                          && (req_chan.src_value[SRC_W-2:0] < 31'(NUM_ACC));
   assign req_dest_addr = req_chan.dest_index[ADDR_W-1:0];
   assign req_src_addr  = req_chan.src_value[ADDR_W-1:0];
   assign dest_addr     = dest_ff[ADDR_W-1:0];

   // Operands, valid while in the read state
   assign dval = dest_vld_ff ? rd_a : '0;
   assign opnd = const_ff ? {{(ACC_W - SRC_W){src_val_ff[SRC_W-1]}}, src_val_ff}
                          : (src_vld_ff ? rd_b : '0);

   assign ram_we = fin_go && wr_en_ff;

   aba_ram #(
      .WIDTH (ACC_W),
      .DEPTH (NUM_ACC)
   ) u_acc_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (dest_addr),
      .wr_data   (res_val_ff),
      .rd_addr_a (req_dest_addr),
      .rd_addr_b (req_src_addr),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   aba_serial u_serial (
      .clock (clock),
      .reset (reset),
      .ctl   (ser_ctl),
      .a_val (dval),
      .b_val (opnd),
      .sts   (ser_sts),
      .sum   (ser_sum)
   );

   aba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dval),
      .divisor  (opnd),
      .sts      (div_sts),
      .quotient (div_q)
   );

   // Instruction sequencer
   always_comb begin
      state_in        = state_ff;
      acc_vld_in      = acc_vld_ff;
      cflag_in        = cflag_ff;
      trap_flag_in    = trap_flag_ff;
      trap_val_in     = trap_val_ff;
      rsp_vld_in      = rsp_vld_ff && !rsp_fire;
      cmd_in          = cmd_ff;
      dest_in         = dest_ff;
      const_in        = const_ff;
      src_val_in      = src_val_ff;
      dest_ok_in      = dest_ok_ff;
      dest_vld_in     = dest_vld_ff;
      src_vld_in      = src_vld_ff;
      status_in       = status_ff;
      branch_in       = branch_ff;
      res_val_in      = res_val_ff;
      wr_en_in        = wr_en_ff;
      trap_set_in     = trap_set_ff;
      clr_in          = clr_ff;
      cmp_set_in      = cmp_set_ff;
      cmp_new_in      = cmp_new_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_branch_in   = rsp_branch_ff;
      rsp_cmp_in      = rsp_cmp_ff;
      rsp_dest_in     = rsp_dest_ff;
      rsp_trap_in     = rsp_trap_ff;
      rsp_trap_val_in = rsp_trap_val_ff;
      ser_ctl.start   = 1'b0;
      ser_ctl.sub     = 1'b0;
      div_start       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_chan.cmd;
               dest_in     = req_chan.dest_index;
               const_in    = req_chan.src_is_constant;
               src_val_in  = req_chan.src_value;
               dest_ok_in  = req_dest_ok;
               dest_vld_in = req_dest_ok && acc_vld_ff[req_dest_addr];
               src_vld_in  = req_src_ok && acc_vld_ff[req_src_addr];
               if (req_chan.program_start) begin
                  cflag_in = CMP_EQ;
               end
               state_in = S_READ;
            end
         end

         // Operands are out of the RAM: decode and launch
         S_READ: begin
            status_in   = ST_OK;
            branch_in   = 1'b0;
            res_val_in  = dval;
            wr_en_in    = 1'b0;
            trap_set_in = 1'b0;
            clr_in      = 1'b0;
            cmp_set_in  = 1'b0;
            state_in    = S_FIN;
            unique case (cmd_ff)
               CMD_ADD, CMD_SUB, CMD_CMP: begin
                  if (!dest_ok_ff) begin
                     status_in = ST_BAD_DEST;
                  end else begin
                     ser_ctl.start = 1'b1;
                     ser_ctl.sub   = (cmd_ff != CMD_ADD);
                     state_in      = S_SER;
                  end
               end
               CMD_DIV: begin
                  if (!dest_ok_ff) begin
                     status_in = ST_BAD_DEST;
                  end else if (opnd == '0) begin
                     status_in   = ST_TRAP;
                     trap_set_in = 1'b1;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               CMD_JEQ: branch_in = (cflag_ff == CMP_EQ);
               CMD_CLEAR: begin
                  clr_in     = 1'b1;
                  res_val_in = '0;
               end
               CMD_NOP: branch_in = 1'b0;
               default: branch_in = 1'b0;
            endcase
         end

         S_SER: begin
            if (ser_sts.done) begin
               if (cmd_ff == CMD_CMP) begin
                  cmp_set_in = 1'b1;
                  cmp_new_in = !ser_sts.ne ? CMP_EQ : (ser_sts.lt ? CMP_LT : CMP_GT);
               end else begin
                  res_val_in = ser_sum;
                  wr_en_in   = 1'b1;
               end
               state_in = S_FIN;
            end
         end

         S_DIV: begin
            if (div_sts.done) begin
               res_val_in = div_q;
               wr_en_in   = 1'b1;
               state_in   = S_FIN;
            end
         end

         // Commit state updates and load the response register
         S_FIN: begin
            if (fin_go) begin
               if (wr_en_ff) begin
                  acc_vld_in[dest_addr] = 1'b1;
               end
               if (clr_ff) begin
                  acc_vld_in   = '0;
                  trap_flag_in = 1'b0;
                  trap_val_in  = '0;
               end else if (trap_set_ff) begin
                  trap_flag_in = 1'b1;
                  trap_val_in  = res_val_ff;
               end
               if (cmp_set_ff) begin
                  cflag_in = cmp_new_ff;
               end
               rsp_status_in   = status_ff;
               rsp_branch_in   = branch_ff;
               rsp_cmp_in      = cmp_set_ff ? cmp_new_ff : cflag_ff;
               rsp_dest_in     = dest_ok_ff ? res_val_ff : '0;
               rsp_trap_in     = trap_flag_in;
               rsp_trap_val_in = trap_val_in;
               rsp_vld_in      = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_vld_ff   <= '0;
         cflag_ff     <= CMP_EQ;
         trap_flag_ff <= 1'b0;
         trap_val_ff  <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_vld_ff   <= acc_vld_in;
         cflag_ff     <= cflag_in;
         trap_flag_ff <= trap_flag_in;
         trap_val_ff  <= trap_val_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      dest_ff         <= dest_in;
      const_ff        <= const_in;
      src_val_ff      <= src_val_in;
      dest_ok_ff      <= dest_ok_in;
      dest_vld_ff     <= dest_vld_in;
      src_vld_ff      <= src_vld_in;
      status_ff       <= status_in;
      branch_ff       <= branch_in;
      res_val_ff      <= res_val_in;
      wr_en_ff        <= wr_en_in;
      trap_set_ff     <= trap_set_in;
      clr_ff          <= clr_in;
      cmp_set_ff      <= cmp_set_in;
      cmp_new_ff      <= cmp_new_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_branch_ff   <= rsp_branch_in;
      rsp_cmp_ff      <= rsp_cmp_in;
      rsp_dest_ff     <= rsp_dest_in;
      rsp_trap_ff     <= rsp_trap_in;
      rsp_trap_val_ff <= rsp_trap_val_in;
   end

   // Response channel
   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.branch_taken  = rsp_branch_ff;
   assign rsp_chan.compare_state = rsp_cmp_ff;
   assign rsp_chan.dest_value    = rsp_dest_ff;
   assign rsp_chan.trap_sticky   = rsp_trap_ff;
   assign rsp_chan.trap_value    = rsp_trap_val_ff;

   // Checks
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_READ)
      else $error("accepted request did not move to the read state");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ser_sts.busy && div_sts.busy))
      else $error("serial unit and divider busy at once");

   a_ser_done_in_ser: assert property (@(posedge clock) disable iff (reset)
      ser_sts.done |-> state_ff == S_SER)
      else $error("serial unit finished outside the serial state");

   a_trap_value_clean: assert property (@(posedge clock) disable iff (reset)
      !trap_flag_ff |-> trap_val_ff == '0)
      else $error("trap value nonzero while trap flag is clear");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff) == S_FIN)
      else $error("response raised outside the commit state");

endmodule

// File: rtl/aba_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module aba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                       rd_data_a,
   output logic [WIDTH-1:0]                       rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/aba_serial.sv
// Bit-serial adder/subtractor and signed comparator, one bit per cycle,
// LSB first. Depends on aba_pkg.
`timescale 1ns / 1ps

module aba_serial import aba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  aba_ser_ctl_type  ctl,
   input  logic [ACC_W-1:0] a_val,
   input  logic [ACC_W-1:0] b_val,
   output aba_ser_sts_type  sts,
   output logic [ACC_W-1:0] sum
);

   logic [ACC_W-1:0] a_sr_ff, a_sr_in;
   logic [ACC_W-1:0] b_sr_ff, b_sr_in;
   logic [ACC_W-1:0] sum_sr_ff, sum_sr_in;
   logic             carry_ff, carry_in;
   logic             sub_ff, sub_in;
   logic             lt_ff, lt_in;
   logic             ne_ff, ne_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic a_bit, b_raw, b_bit, s_bit, c_out, last;

   // One full-adder slice; subtraction inverts b and starts with carry in
   assign a_bit = a_sr_ff[0];
   assign b_raw = b_sr_ff[0];
   assign b_bit = b_raw ^ sub_ff;
   assign s_bit = a_bit ^ b_bit ^ carry_ff;
   assign c_out = (a_bit & b_bit) | (a_bit & carry_ff) | (b_bit & carry_ff);
   assign last  = (cnt_ff == CNT_W'(ACC_W - 1));

   always_comb begin
      a_sr_in   = a_sr_ff;
      b_sr_in   = b_sr_ff;
      sum_sr_in = sum_sr_ff;
      carry_in  = carry_ff;
      sub_in    = sub_ff;
      lt_in     = lt_ff;
      ne_in     = ne_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctl.start) begin
         a_sr_in  = a_val;
         b_sr_in  = b_val;
         carry_in = ctl.sub;
         sub_in   = ctl.sub;
         lt_in    = 1'b0;
         ne_in    = 1'b0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         a_sr_in   = {1'b0, a_sr_ff[ACC_W-1:1]};
         b_sr_in   = {1'b0, b_sr_ff[ACC_W-1:1]};
         sum_sr_in = {s_bit, sum_sr_ff[ACC_W-1:1]};
         carry_in  = c_out;
         // Highest differing bit decides; the sign bit weighs negative
         if (a_bit != b_raw) begin
            ne_in = 1'b1;
            lt_in = last ? a_bit : b_raw;
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sr_ff   <= a_sr_in;
      b_sr_ff   <= b_sr_in;
      sum_sr_ff <= sum_sr_in;
      carry_ff  <= carry_in;
      sub_ff    <= sub_in;
      lt_ff     <= lt_in;
      ne_ff     <= ne_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.lt   = lt_ff;
   assign sts.ne   = ne_ff;
   assign sum      = sum_sr_ff;

endmodule

// File: rtl/aba_div.sv
// Signed truncating divider: restoring shift/subtract, one quotient bit per
// cycle, with one shared negator for operand magnitudes and sign fix.
// Depends on aba_pkg.
`timescale 1ns / 1ps

module aba_div import aba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ACC_W-1:0] dividend,
   input  logic [ACC_W-1:0] divisor,
   output aba_div_sts_type  sts,
   output logic [ACC_W-1:0] quotient
);

   localparam logic [2:0] D_IDLE = 3'd0;
   localparam logic [2:0] D_NEGA = 3'd1;
   localparam logic [2:0] D_NEGB = 3'd2;
   localparam logic [2:0] D_ITER = 3'd3;
   localparam logic [2:0] D_FIX  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [ACC_W-1:0] a_ff, a_in;
   logic [ACC_W-1:0] b_ff, b_in;
   logic [ACC_W-1:0] q_ff, q_in;
   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0] magb_ff, magb_in;

   logic [ACC_W-1:0] neg_src, neg_out, rem_sh;
   logic [ACC_W:0]   trial;
   logic             fits;

   // Shared negator
   always_comb begin
      unique case (state_ff)
         D_NEGA:  neg_src = a_ff;
         D_NEGB:  neg_src = b_ff;
         default: neg_src = q_ff;
      endcase
   end
   assign neg_out = '0 - neg_src;

   // Remainder stays below the divisor magnitude, so its top bit is zero
   assign rem_sh = {rem_ff[ACC_W-2:0], q_ff[ACC_W-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, magb_ff};
   assign fits   = !trial[ACC_W];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      magb_in  = magb_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               a_in     = dividend;
               b_in     = divisor;
               state_in = D_NEGA;
            end
         end
         D_NEGA: begin
            q_in     = a_ff[ACC_W-1] ? neg_out : a_ff;
            rem_in   = '0;
            state_in = D_NEGB;
         end
         D_NEGB: begin
            magb_in  = b_ff[ACC_W-1] ? neg_out : b_ff;
            cnt_in   = '0;
            state_in = D_ITER;
         end
         D_ITER: begin
            rem_in = fits ? trial[ACC_W-1:0] : rem_sh;
            q_in   = {q_ff[ACC_W-2:0], fits};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ACC_W - 1)) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            q_in     = (a_ff[ACC_W-1] ^ b_ff[ACC_W-1]) ? neg_out : q_ff;
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      magb_ff <= magb_in;
   end

   assign sts.busy = (state_ff != D_IDLE);
   assign sts.done = done_ff;
   assign quotient = q_ff;

endmodule
